// File: rtl/quaternion_to_rotation_matrix_macros.svh
// Assertion macros shared by the quaternion to rotation matrix RTL.
`ifndef QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH

// Implication checked in the same cycle, disabled during reset.
`define QDCM_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qdcm assertion failed");

// Implication checked in the following cycle, active also during reset.
`define QDCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("qdcm assertion failed");

`endif

// File: rtl/qdcm_pkg.sv
// Package with widths and types for the quaternion to rotation matrix pipeline.
package qdcm_pkg;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 16;
  localparam int OUT_FRAC = OUT_W - 2;
  localparam int NENT     = 9;
  localparam int NCOMP    = 4;
  localparam int PROD_W   = 2 * IN_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int NUM_W    = PROD_W + 2;
  localparam int ROOT_W   = (SUM_W + 1) / 2;
  localparam int REM_W    = ROOT_W + 4;
  localparam int EPS_W    = 8;
  localparam int D_W      = ROOT_W;
  localparam int D2_W     = 2 * D_W;
  localparam int MAG_W    = NUM_W - 1;
  localparam int QB       = OUT_W;
  localparam int DW       = D2_W + QB;

  localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(1) << OUT_FRAC;

  typedef logic signed [NUM_W-1:0] num_t;
  typedef num_t [NENT-1:0] num_vec_t;
endpackage

// File: rtl/qdcm_prod.sv
// Product stages: component products, norm sum and matrix numerators.
module qdcm_prod (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 in_valid,
  input  logic [qdcm_pkg::NCOMP*qdcm_pkg::IN_W-1:0] in_data,
  output logic                                 out_valid,
  output logic [qdcm_pkg::SUM_W-1:0]           out_sum,
  output qdcm_pkg::num_vec_t                   out_num
);
  import qdcm_pkg::*;

  logic signed [IN_W-1:0]   s, a, b, c;
  logic                     v1_r;
  logic signed [PROD_W-1:0] ss_r, aa_r, bb_r, cc_r, ab_r, sc_r, ac_r, sb_r, bc_r, sa_r;
  logic                     v2_r;
  logic [SUM_W-1:0]         sum_r;
  num_vec_t                 num_r, num_nxt;

  assign s = $signed(in_data[IN_W-1:0]);
  assign a = $signed(in_data[2*IN_W-1:IN_W]);
  assign b = $signed(in_data[3*IN_W-1:2*IN_W]);
  assign c = $signed(in_data[4*IN_W-1:3*IN_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ss_r  <= s * s;
      aa_r  <= a * a;
      bb_r  <= b * b;
      cc_r  <= c * c;
      ab_r  <= a * b;
      sc_r  <= s * c;
      ac_r  <= a * c;
      sb_r  <= s * b;
      bc_r  <= b * c;
      sa_r  <= s * a;
      sum_r <= SUM_W'($unsigned(ss_r)) + SUM_W'($unsigned(aa_r))
             + SUM_W'($unsigned(bb_r)) + SUM_W'($unsigned(cc_r));
      num_r <= num_nxt;
    end
  end

  always_comb begin
    num_nxt[0] = NUM_W'(ss_r) + NUM_W'(aa_r) - NUM_W'(bb_r) - NUM_W'(cc_r);
    num_nxt[1] = (NUM_W'(ab_r) + NUM_W'(sc_r)) <<< 1;
    num_nxt[2] = (NUM_W'(ac_r) - NUM_W'(sb_r)) <<< 1;
    num_nxt[3] = (NUM_W'(ab_r) - NUM_W'(sc_r)) <<< 1;
    num_nxt[4] = NUM_W'(ss_r) - NUM_W'(aa_r) + NUM_W'(bb_r) - NUM_W'(cc_r);
    num_nxt[5] = (NUM_W'(bc_r) + NUM_W'(sa_r)) <<< 1;
    num_nxt[6] = (NUM_W'(ac_r) + NUM_W'(sb_r)) <<< 1;
    num_nxt[7] = (NUM_W'(bc_r) - NUM_W'(sa_r)) <<< 1;
    num_nxt[8] = NUM_W'(ss_r) - NUM_W'(aa_r) - NUM_W'(bb_r) + NUM_W'(cc_r);
  end

  assign out_valid = v2_r;
  assign out_sum   = sum_r;
  assign out_num   = num_r;
endmodule

// File: rtl/qdcm_sqrt.sv
// Pipelined integer square root, one root bit per stage, numerators carried along.
module qdcm_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [qdcm_pkg::SUM_W-1:0]  in_x,
  input  qdcm_pkg::num_vec_t          in_num,
  output logic                        out_valid,
  output logic [qdcm_pkg::ROOT_W-1:0] out_root,
  output qdcm_pkg::num_vec_t          out_num
);
  import qdcm_pkg::*;

  localparam int XW = 2 * ROOT_W;

  logic              v_r    [ROOT_W];
  logic [XW-1:0]     x_r    [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  num_vec_t          num_r  [ROOT_W];

  logic              sv     [ROOT_W];
  logic [XW-1:0]     sx     [ROOT_W];
  logic [REM_W-1:0]  srem   [ROOT_W];
  logic [ROOT_W-1:0] sroot  [ROOT_W];
  num_vec_t          snum   [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0]  rem_sh, trial, rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign sv[k]    = in_valid;
      assign sx[k]    = XW'(in_x);
      assign srem[k]  = '0;
      assign sroot[k] = '0;
      assign snum[k]  = in_num;
    end else begin : g_next
      assign sv[k]    = v_r[k-1];
      assign sx[k]    = x_r[k-1];
      assign srem[k]  = rem_r[k-1];
      assign sroot[k] = root_r[k-1];
      assign snum[k]  = num_r[k-1];
    end

    always_comb begin
      rem_sh = {srem[k][REM_W-3:0], sx[k][XW-1 -: 2]};
      trial  = REM_W'({sroot[k], 2'b01});
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {sroot[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {sroot[k][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[k]    <= sx[k] << 2;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        num_r[k]  <= snum[k];
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_num   = num_r[ROOT_W-1];
endmodule

// File: rtl/qdcm_div.sv
// One matrix entry lane: pipelined rounded division by the squared norm with saturation.
`include "quaternion_to_rotation_matrix_macros.svh"

module qdcm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_valid,
  input  qdcm_pkg::num_t             in_num,
  input  logic [qdcm_pkg::D2_W-1:0]  in_d2,
  output logic                       out_valid,
  output logic [qdcm_pkg::OUT_W-1:0] out_ent
);
  import qdcm_pkg::*;

  logic             neg;
  logic [MAG_W-1:0] mag;

  logic             v_r    [QB+1];
  logic [DW-1:0]    n_r    [QB+1];
  logic [D2_W-1:0]  d2_r   [QB+1];
  logic [QB-1:0]    q_r    [QB+1];
  logic             neg_r  [QB+1];
  logic             sat_r  [QB+1];
  logic             zero_r [QB+1];

  logic             res_v_r;
  logic [OUT_W-1:0] res_r, res_nxt, mq;

  assign neg = in_num[NUM_W-1];
  assign mag = MAG_W'(neg ? -in_num : in_num);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r[0]    <= (DW'(mag) << OUT_FRAC) + DW'(in_d2 >> 1);
      d2_r[0]   <= in_d2;
      q_r[0]    <= '0;
      neg_r[0]  <= neg;
      sat_r[0]  <= DW'(mag) >= (DW'(in_d2) << 1);
      zero_r[0] <= in_d2 == '0;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    logic [DW-1:0] dsh;
    logic          take;

    assign dsh  = DW'(d2_r[j-1]) << (QB - j);
    assign take = n_r[j-1] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (adv) begin
        v_r[j] <= v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        n_r[j]    <= take ? n_r[j-1] - dsh : n_r[j-1];
        d2_r[j]   <= d2_r[j-1];
        q_r[j]    <= q_r[j-1] | (QB'(take) << (QB - j));
        neg_r[j]  <= neg_r[j-1];
        sat_r[j]  <= sat_r[j-1];
        zero_r[j] <= zero_r[j-1];
      end
    end
  end

  always_comb begin
    mq = (sat_r[QB] || (q_r[QB] > OUT_ONE)) ? OUT_ONE : q_r[QB];
    if (zero_r[QB]) begin
      res_nxt = '0;
    end else if (neg_r[QB]) begin
      res_nxt = -mq;
    end else begin
      res_nxt = mq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (adv) begin
      res_v_r <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_v_r;
  assign out_ent   = res_r;

  `QDCM_ASSERT(a_ent_range, res_v_r,
    ($signed(res_r) <= $signed(OUT_ONE)) && ($signed(res_r) >= -$signed(OUT_ONE)))
  `QDCM_ASSERT(a_zero_div, v_r[QB] && zero_r[QB], res_nxt == '0)
endmodule

// File: rtl/quaternion_to_rotation_matrix.sv
// Top level: quaternion to rotation matrix conversion pipeline.
// The block converts a quaternion (scalar first, each component signed Q3.12)
// into the nine row-major entries of its rotation matrix in signed Q1.14.
// Input transactions arrive on in_tvalid/in_tready/in_tdata, results leave on
// out_tvalid/out_tready/out_tdata, one result transaction per input.
// The quaternion is divided by its integer norm plus norm_epsilon; the user must
// write it through cfg_wen/cfg_wdata only while the block is idle; the block does not enforce it.
// The pipeline has two product stages, seventeen square root stages (one root bit
// each), two norm stages and eighteen divider stages per entry lane (one quotient
// bit in each but the first and the last).
// Throughput is one quaternion per cycle while the pipeline is not held.
// When out_tready is low with a result waiting, the whole pipeline holds and
// in_tready drops in the same cycle; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and sets norm_epsilon to 1.
`include "quaternion_to_rotation_matrix_macros.svh"

module quaternion_to_rotation_matrix (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // q_scalar [15:0], q_i [31:16], q_j [47:32], q_k [63:48]
  input  logic [qdcm_pkg::NCOMP*qdcm_pkg::IN_W-1:0] in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // dcm_00 [15:0], dcm_01, dcm_02, dcm_10, dcm_11, dcm_12, dcm_20, dcm_21, dcm_22 [143:128]
  output logic [qdcm_pkg::NENT*qdcm_pkg::OUT_W-1:0] out_tdata,
  input  logic                                    cfg_wen,
  input  logic [qdcm_pkg::EPS_W-1:0]              cfg_wdata
);
  import qdcm_pkg::*;

  logic              adv;
  logic [EPS_W-1:0]  norm_epsilon_r;

  logic              p_valid;
  logic [SUM_W-1:0]  p_sum;
  num_vec_t          p_num;

  logic              r_valid;
  logic [ROOT_W-1:0] r_root;
  num_vec_t          r_num;

  logic              vd_r, vq_r;
  logic [D_W-1:0]    d_r;
  logic [D2_W-1:0]   d2_r;
  num_vec_t          numd_r, numq_r;

  logic [NENT-1:0]   lane_valid;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_epsilon_r <= EPS_W'(1);
    end else if (cfg_wen) begin
      norm_epsilon_r <= cfg_wdata;
    end
  end

  qdcm_prod u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .out_valid (p_valid),
    .out_sum   (p_sum),
    .out_num   (p_num)
  );

  qdcm_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (p_valid),
    .in_x      (p_sum),
    .in_num    (p_num),
    .out_valid (r_valid),
    .out_root  (r_root),
    .out_num   (r_num)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      vq_r <= 1'b0;
    end else if (adv) begin
      vd_r <= r_valid;
      vq_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r    <= D_W'(r_root) + D_W'(norm_epsilon_r);
      numd_r <= r_num;
      d2_r   <= D2_W'(d_r) * D2_W'(d_r);
      numq_r <= numd_r;
    end
  end

  for (genvar e = 0; e < NENT; e++) begin : g_lane
    qdcm_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (vq_r),
      .in_num    (numq_r[e]),
      .in_d2     (d2_r),
      .out_valid (lane_valid[e]),
      .out_ent   (out_tdata[e*OUT_W +: OUT_W])
    );
  end

  assign out_tvalid = lane_valid[0];

  `QDCM_ASSERT(a_stall_only_full, !in_tready, out_tvalid)
  `QDCM_ASSERT(a_lanes_agree, 1'b1, (lane_valid == '0) || (lane_valid == '1))
  `QDCM_ASSERT_NEXT(a_reset_empty, !rst_n, !out_tvalid)
endmodule

// File: tb/quaternion_to_rotation_matrix_tb.sv
// Self-checking testbench for the quaternion to rotation matrix converter.
module quaternion_to_rotation_matrix_tb;
  import qdcm_pkg::*;

  localparam int LATENCY = 39;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] k;
    logic signed [15:0] j;
    logic signed [15:0] i;
    logic signed [15:0] s;
  } quat_t;

  typedef logic [NENT*OUT_W-1:0] dcm_t;

  class dcm_scoreboard;
    dcm_t pending_dcm[$];
    int errors;
    int checked;
    logic [EPS_W-1:0] epsilon;

    function new();
      errors = 0;
      checked = 0;
      epsilon = 1;
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function logic [OUT_W-1:0] scaled_entry(longint num, longint unsigned den2);
      longint unsigned mag;
      longint unsigned q;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      q = (mag * (64'd1 << OUT_FRAC) + den2 / 2) / den2;
      if (q > (64'd1 << OUT_FRAC)) q = 64'd1 << OUT_FRAC;
      if (num < 0) q = -q;
      return q[OUT_W-1:0];
    endfunction

    function void note_quaternion(quat_t qv);
      longint s, a, b, c, ss, aa, bb, cc;
      longint unsigned d, d2;
      longint nums[9];
      dcm_t m;
      s = qv.s; a = qv.i; b = qv.j; c = qv.k;
      ss = s * s; aa = a * a; bb = b * b; cc = c * c;
      d = int_sqrt(ss + aa + bb + cc) + epsilon;
      d2 = d * d;
      nums[0] = ss + aa - bb - cc;
      nums[1] = 2 * (a * b + s * c);
      nums[2] = 2 * (a * c - s * b);
      nums[3] = 2 * (a * b - s * c);
      nums[4] = ss - aa + bb - cc;
      nums[5] = 2 * (b * c + s * a);
      nums[6] = 2 * (a * c + s * b);
      nums[7] = 2 * (b * c - s * a);
      nums[8] = ss - aa - bb + cc;
      m = '0;
      if (d2 != 0)
        for (int n = 0; n < NENT; n++) m[n*OUT_W +: OUT_W] = scaled_entry(nums[n], d2);
      pending_dcm.push_back(m);
    endfunction

    function void check_matrix(dcm_t got);
      dcm_t want;
      if (pending_dcm.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_dcm.pop_front();
      checked++;
      for (int n = 0; n < NENT; n++)
        if (got[n*OUT_W +: OUT_W] !== want[n*OUT_W +: OUT_W]) begin
          $display("%0t: entry %0d expected %h actual %h", $time, n,
                   want[n*OUT_W +: OUT_W], got[n*OUT_W +: OUT_W]);
          errors++;
        end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  quat_t in_tdata;
  dcm_t out_tdata;
  logic cfg_wen;
  logic [EPS_W-1:0] cfg_wdata;
  dcm_scoreboard board;
  int cycle_count;
  int stall_mode;
  int sent;

  quaternion_to_rotation_matrix u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    board = new();
    rst_n = 0; in_tvalid = 0; in_tdata = '0; out_tready = 0;
    cfg_wen = 0; cfg_wdata = '0;
    stall_mode = 0; cycle_count = 0; sent = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver stall pattern switches between four randomly chosen modes.
  always @(posedge clk) begin
    if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 1) != 0);
      default: out_tready <= ((cycle_count % 16) < 10);
    endcase
    if (rst_n && out_tvalid && out_tready) board.check_matrix(out_tdata);
  end

  task automatic send_quaternion(quat_t qv);
    in_tvalid <= 1'b1;
    in_tdata <= qv;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_quaternion(qv);
    sent++;
  endtask

  task automatic idle_gap(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    idle_gap(1);
    while (board.pending_dcm.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [EPS_W-1:0] value);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    board.epsilon = value;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 64)) - 16'd32;
      1: return 16'h8000 + 16'($urandom_range(0, 3));
      2: return 16'h7fff - 16'($urandom_range(0, 3));
      3: return 16'($urandom_range(0, 8192)) - 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_burst(int count);
    quat_t qv;
    int left;
    left = count;
    while (left > 0) begin
      for (int n = $urandom_range(1, 20); n > 0 && left > 0; n--) begin
        qv.s = rand_comp(); qv.i = rand_comp(); qv.j = rand_comp(); qv.k = rand_comp();
        send_quaternion(qv);
        left--;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
    end
  endtask

  initial begin
    logic [EPS_W-1:0] eps_list[5];
    eps_list = '{8'd0, 8'd255, 8'd1, 8'd17, 8'd128};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cases at reset epsilon, then with a zero epsilon.
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) write_epsilon(8'd0);
      send_quaternion('0);
      send_quaternion(quat_t'({16'sd0, 16'sd0, 16'sd0, 16'sd4096}));
      send_quaternion(quat_t'({16'sd0, 16'sd0, 16'sd4096, 16'sd0}));
      send_quaternion(quat_t'({16'sd0, 16'sd4096, 16'sd0, 16'sd0}));
      send_quaternion(quat_t'({16'sd4096, 16'sd0, 16'sd0, 16'sd0}));
      send_quaternion(quat_t'({16'h8000, 16'h8000, 16'h8000, 16'h8000}));
      send_quaternion(quat_t'({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}));
      send_quaternion(quat_t'({16'h7fff, 16'h8000, 16'h7fff, 16'h8000}));
      send_quaternion(quat_t'({16'sd1, 16'sd1, 16'sd1, 16'sd1}));
      send_quaternion(quat_t'({16'sd0, 16'sd0, 16'sd0, 16'sd1}));
      send_quaternion(quat_t'({16'sd3, -16'sd2, 16'sd7, -16'sd5}));
      drain();
    end

    foreach (eps_list[e]) begin
      write_epsilon(eps_list[e]);
      random_burst(280);
      drain();
    end

    $display("Sent %0d quaternions and checked %0d matrices over %0d epsilon values.",
             sent, board.checked, 5);
    if (board.errors == 0 && board.pending_dcm.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
